@@ rtl/ism_pkg.sv @@
// Shared types and constants for the inverse square root mod 2^k block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ism_pkg;
  localparam int ISM_WORD_WIDTH  = 64;
  localparam int FIELD_W         = 64;
  localparam int RING_BITS_W     = 7;
  localparam logic [RING_BITS_W-1:0] RING_BITS_RESET = 7'd64;
  localparam int PADDR_W         = 3;
  localparam logic REG_RING_BITS = 1'b0;

  typedef struct packed {
    logic valid;
    logic last;
  } ism_ctrl_t;
endpackage
`default_nettype wire

@@ rtl/ism_if.sv @@
// Item channel interfaces: input element and result element.
// Depends on ism_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface ism_in_if;
  logic                        valid;
  logic                        ready;
  logic [ism_pkg::FIELD_W-1:0] square_value;
  logic                        item_last;
  modport source (output valid, square_value, item_last, input ready);
  modport sink (input valid, square_value, item_last, output ready);
endinterface

interface ism_out_if;
  logic                        valid;
  logic                        ready;
  logic [ism_pkg::FIELD_W-1:0] inv_root;
  logic                        result_last;
  modport source (output valid, inv_root, result_last, input ready);
  modport sink (input valid, inv_root, result_last, output ready);
endinterface
`default_nettype wire

@@ rtl/inverse_sqrt_mod_pow2_top.sv @@
// Top level: APB register, chain of lifting cells, final round, result register.
// Depends on ism_pkg, ism_if, ism_cell.
//
// Usage: elements enter on req (valid/ready), results leave on rsp.
// Register ring_bits (byte address 0) sets k; values above WORD_WIDTH act
// as WORD_WIDTH. Write it only while no item is in flight.
// The chain has WORD_WIDTH-3 cells, one per lifted bit; each cell holds one
// item and passes it on every cycle unless rsp stalls, so rsp.valid rises once
// the item has passed every cell and the result register, independent of k,
// and a new item can be taken every cycle unless rsp stalls.
// The final round sets the top bit and loads the result register.
// When rsp stalls with a result held, the whole chain freezes and req.ready
// drops; nothing is lost. Reset empties the chain and sets ring_bits to 64.
`timescale 1ns / 1ps
`default_nettype none
module inverse_sqrt_mod_pow2_top #(
  parameter int WORD_WIDTH = ism_pkg::ISM_WORD_WIDTH
) (
  input  wire                           clk,
  input  wire                           rst,
  ism_in_if.sink                        req,
  ism_out_if.source                     rsp,
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire [ism_pkg::PADDR_W-1:0]    paddr,
  input  wire [31:0]                    pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ism_pkg::*;

  localparam int NCELL = WORD_WIDTH - 3;
  localparam int IDX_W = $clog2(WORD_WIDTH);
  localparam logic [RING_BITS_W-1:0] WW_K = RING_BITS_W'(WORD_WIDTH);

  logic [RING_BITS_W-1:0] ring_bits;
  logic [RING_BITS_W-1:0] k_eff;
  logic                   adv;
  logic [IDX_W-1:0]       fin;
  logic [WORD_WIDTH-1:0]  res_next;

  ism_ctrl_t             ctrl_s [0:NCELL];
  logic [WORD_WIDTH-1:0] root_s [0:NCELL];
  logic [WORD_WIDTH-1:0] inv_s  [0:NCELL];
  logic [WORD_WIDTH-1:0] d1_s   [0:NCELL];
  logic [WORD_WIDTH-1:0] d2_s   [0:NCELL];

  assign pready = 1'b1;
  assign prdata = {{(32 - RING_BITS_W){1'b0}}, ring_bits};

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_bits <= RING_BITS_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_RING_BITS)) begin
      ring_bits <= pwdata[RING_BITS_W-1:0];
    end
  end

  assign k_eff = (ring_bits > WW_K) ? WW_K : ring_bits;
  assign adv   = !rsp.valid || rsp.ready;
  assign req.ready = adv;

  always_comb begin
    ctrl_s[0].valid = req.valid;
    ctrl_s[0].last  = req.item_last;
    root_s[0] = WORD_WIDTH'(1);
    inv_s[0]  = WORD_WIDTH'(1);
    d1_s[0]   = req.square_value[WORD_WIDTH-1:0] - WORD_WIDTH'(1);
    d2_s[0]   = '0;
  end

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    ism_cell #(
      .WORD_WIDTH(WORD_WIDTH),
      .POS(i + 2)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .adv(adv),
      .k_eff(k_eff),
      .ctrl_in(ctrl_s[i]),
      .root_in(root_s[i]),
      .inv_in(inv_s[i]),
      .d1_in(d1_s[i]),
      .d2_in(d2_s[i]),
      .ctrl_out(ctrl_s[i+1]),
      .root_out(root_s[i+1]),
      .inv_out(inv_s[i+1]),
      .d1_out(d1_s[i+1]),
      .d2_out(d2_s[i+1])
    );
  end

  always_comb begin
    fin = (k_eff >= RING_BITS_W'(3)) ? IDX_W'(k_eff - RING_BITS_W'(1)) : IDX_W'(2);
    res_next = inv_s[NCELL] + (WORD_WIDTH'(d2_s[NCELL][fin]) << fin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (adv) begin
      rsp.valid <= ctrl_s[NCELL].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.inv_root    <= FIELD_W'(res_next);
      rsp.result_last <= ctrl_s[NCELL].last;
    end
  end

  a_odd_result: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.inv_root[0])
    else $error("result is not odd");

  a_k_bound: assert property (@(posedge clk) disable iff (rst)
    k_eff <= WW_K)
    else $error("effective k exceeds word width");

  a_chain_out: assert property (@(posedge clk) disable iff (rst)
    (adv && ctrl_s[NCELL].valid) |=> rsp.valid)
    else $error("item lost at end of chain");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(ctrl_s[NCELL]))
    else $error("chain moved while stalled");
endmodule
`default_nettype wire

@@ rtl/ism_cell.sv @@
// One lifting cell: settles bit POS of the root and inverse estimates.
// Tracks e - r*r and 1 - r*v by shift-adds. Depends on ism_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ism_cell #(
  parameter int WORD_WIDTH = ism_pkg::ISM_WORD_WIDTH,
  parameter int POS        = 2
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               adv,
  input  wire [ism_pkg::RING_BITS_W-1:0]    k_eff,
  input  ism_pkg::ism_ctrl_t                ctrl_in,
  input  wire [WORD_WIDTH-1:0]              root_in,
  input  wire [WORD_WIDTH-1:0]              inv_in,
  input  wire [WORD_WIDTH-1:0]              d1_in,
  input  wire [WORD_WIDTH-1:0]              d2_in,
  output ism_pkg::ism_ctrl_t                ctrl_out,
  output logic [WORD_WIDTH-1:0]             root_out,
  output logic [WORD_WIDTH-1:0]             inv_out,
  output logic [WORD_WIDTH-1:0]             d1_out,
  output logic [WORD_WIDTH-1:0]             d2_out
);
  import ism_pkg::*;

  localparam logic [WORD_WIDTH-1:0] BIT_POS = WORD_WIDTH'(1) << POS;
  localparam logic [WORD_WIDTH-1:0] SQ_POS  =
    (2 * POS < WORD_WIDTH) ? (WORD_WIDTH'(1) << (2 * POS)) : '0;
  localparam logic [RING_BITS_W-1:0] POS_P1 = RING_BITS_W'(POS + 1);

  logic                  active;
  logic                  rbit;
  logic                  vbit;
  logic [WORD_WIDTH-1:0] root_n;
  logic [WORD_WIDTH-1:0] d1_n;
  logic [WORD_WIDTH-1:0] d2a;
  logic [WORD_WIDTH-1:0] inv_n;
  logic [WORD_WIDTH-1:0] d2_n;

  always_comb begin
    active = (k_eff > POS_P1);
    rbit   = active & d1_in[POS+1];
    root_n = rbit ? (root_in | BIT_POS) : root_in;
    d1_n   = rbit ? (d1_in - (root_in << (POS + 1)) - SQ_POS) : d1_in;
    d2a    = rbit ? (d2_in - (inv_in << POS)) : d2_in;
    vbit   = active & d2a[POS];
    inv_n  = vbit ? (inv_in + BIT_POS) : inv_in;
    d2_n   = vbit ? (d2a - (root_n << POS)) : d2a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else if (adv) begin
      ctrl_out <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      root_out <= root_n;
      inv_out  <= inv_n;
      d1_out   <= d1_n;
      d2_out   <= d2_n;
    end
  end
endmodule
`default_nettype wire

@@ sim/tb_inverse_sqrt_mod_pow2_top.sv @@
// Testbench for inverse_sqrt_mod_pow2_top: drives elements with random idling,
// predicts the inverse square root mod 2^k, checks each result in order.
// Depends on ism_pkg, ism_if and the block's RTL.
`timescale 1ns / 1ps
module tb_inverse_sqrt_mod_pow2_top;
  import ism_pkg::*;

  typedef struct packed {
    logic [FIELD_W-1:0] inv_root;
    logic               last;
  } inv_result_t;

  localparam int LATENCY = ISM_WORD_WIDTH;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ism_in_if req ();
  ism_out_if rsp ();

  inverse_sqrt_mod_pow2_top dut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  int unsigned ring_k = RING_BITS_RESET;
  inv_result_t expected_q[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned quiet_cycles = 0;
  int unsigned errors = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    req.valid = 1'b0;
    req.square_value = '0;
    req.item_last = 1'b0;
    rsp.ready = 1'b0;
  end

  function automatic logic [63:0] inverse_root(logic [63:0] e, int unsigned k);
    logic [63:0] root, inv, mask, diff;
    int unsigned kk;
    root = 64'd1;
    inv = 64'd1;
    mask = 64'd4;
    kk = (k > ISM_WORD_WIDTH) ? ISM_WORD_WIDTH : k;
    for (int unsigned j = 2; j + 1 < kk; j++) begin
      diff = e - root * root;
      root = root + ((diff & (mask << 1)) >> 1);
      diff = 64'd1 - root * inv;
      inv = inv + (diff & mask);
      mask = mask << 1;
    end
    diff = 64'd1 - root * inv;
    return inv + (diff & mask);
  endfunction

  // receiver: random stalls, plus an optional long hold-off
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_cycles != 0) begin
      rsp.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result inv_root=%h", rsp.inv_root);
        errors++;
      end else begin
        inv_result_t exp_r;
        exp_r = expected_q.pop_front();
        if (rsp.inv_root !== exp_r.inv_root) begin
          $error("inv_root expected %h actual %h", exp_r.inv_root, rsp.inv_root);
          errors++;
        end
        if (rsp.result_last !== exp_r.last) begin
          $error("result_last expected %b actual %b", exp_r.last, rsp.result_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_inverse_sqrt_mod_pow2_top NOT OK");
        $finish;
      end
    end
  end

  // valid stays high after an accept until the next item or an idle cycle
  task automatic send_element(logic [63:0] e, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.square_value <= e;
    req.item_last <= last;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    expected_q.push_back('{inverse_root(e, ring_k), last});
    @(negedge clk);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);
  endtask

  task automatic write_ring_bits(int unsigned k);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(REG_RING_BITS) << 2;
    pwdata <= k;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    ring_k = k & 7'h7f;
  endtask

  function automatic logic [63:0] odd_square();
    logic [63:0] a;
    a = {$urandom, $urandom} | 64'd1;
    return a * a;
  endfunction

  function automatic logic [63:0] random_element();
    case ($urandom_range(9))
      0: return {$urandom, $urandom};
      1: return {$urandom, $urandom} & ~64'd1;
      default: return odd_square();
    endcase
  endfunction

  task automatic test_directed();
    logic [63:0] edges[$] = '{64'd0, 64'd1, 64'd9, 64'd25, 64'hFFFF_FFFF_FFFF_FFFF,
      64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAB,
      64'hFFFF_FFFF_FFFF_FFF9, 64'd49};
    foreach (edges[i]) send_element(edges[i], i[0]);
    for (int i = 0; i < 8; i++) send_element(odd_square(), i == 7);
  endtask

  task automatic test_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      send_element(random_element(), $urandom_range(1));
  endtask

  task automatic test_ring_sizes();
    int unsigned sizes[$] = '{4, 3, 0, 127, 65, 63, 5, 32, 17};
    foreach (sizes[i]) begin
      write_ring_bits(sizes[i]);
      test_random(12);
      drain();
    end
    write_ring_bits(64);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    hold_cycles = 3 * LATENCY;
    test_random(3 * LATENCY);
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    drain();
    test_directed();
    drain();
    test_ring_sizes();
    send_idle_pct = 35;
    recv_idle_pct = 85;
    test_random(200);
    send_idle_pct = 85;
    recv_idle_pct = 35;
    test_random(200);
    drain();
    write_ring_bits($urandom_range(4, 64));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(200);
    drain();
    test_backpressure();
    if (errors == 0) begin
      $display("tb_inverse_sqrt_mod_pow2_top OK");
    end else begin
      $display("tb_inverse_sqrt_mod_pow2_top NOT OK");
    end
    $finish;
  end
endmodule
